FILE: sv/round_robin_quantum_scheduler_unit_macros.svh
// Assertion macros shared by the round-robin scheduler RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRQS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rrqs_pkg.sv
// Types and constants for the round-robin quantum scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package rrqs_pkg;

    localparam int ID_W   = 16;
    localparam int LEN_W  = 10;
    localparam int TIME_W = 32;

    localparam logic REQ_ADD      = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ADDED      = 2'd0,
        STATUS_DISPATCHED = 2'd1,
        STATUS_EMPTY      = 2'd2,
        STATUS_FULL       = 2'd3
    } status_t;

    // One queued task as held in the ring memory.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  remaining;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] last_enq;
        logic [TIME_W-1:0] wait_sum;
    } entry_t;

    // One result beat.
    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   served_id;
        logic [TIME_W-1:0] slice_start;
        logic [LEN_W-1:0]  slice_length;
        logic [TIME_W-1:0] wait_this_turn;
        logic [LEN_W-1:0]  time_left;
        logic              task_done;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] total_wait;
        logic [TIME_W-1:0] clock_now;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/round_robin_quantum_scheduler_unit.sv
// Round-robin time-slice scheduler over a ring of QUEUE_DEPTH tasks. Each request
// beat (add a task, or dispatch one slice of the head task) produces exactly one
// result beat, in the cycle after it is accepted; a new request is accepted in every
// cycle while the result register is empty or being drained. The rate is set by
// the ring memory's registered read port: the head entry is prefetched each cycle
// at the next head address, with same-cycle writes forwarded, so back-to-back
// dispatches never wait on the memory. No clearing pass follows reset; entries
// are only read once written. The scheduler clock wraps at 32 bits.
// Depends on rrqs_pkg, rrqs_entry_ram, rrqs_slice_calc and the assertion macros.
`default_nettype none

`include "round_robin_quantum_scheduler_unit_macros.svh"

module round_robin_quantum_scheduler_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        cfg_wr_en,
    input  wire logic [rrqs_pkg::LEN_W-1:0]  cfg_wr_data,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_req_type,
    input  wire logic [rrqs_pkg::ID_W-1:0]   s_task_id,
    input  wire logic [rrqs_pkg::LEN_W-1:0]  s_burst_length,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [1:0]                       m_status,
    output logic [rrqs_pkg::ID_W-1:0]        m_served_id,
    output logic [rrqs_pkg::TIME_W-1:0]      m_slice_start,
    output logic [rrqs_pkg::LEN_W-1:0]       m_slice_length,
    output logic [rrqs_pkg::TIME_W-1:0]      m_wait_this_turn,
    output logic [rrqs_pkg::LEN_W-1:0]       m_time_left,
    output logic                             m_task_done,
    output logic [rrqs_pkg::TIME_W-1:0]      m_turnaround,
    output logic [rrqs_pkg::TIME_W-1:0]      m_total_wait,
    output logic [rrqs_pkg::TIME_W-1:0]      m_clock_now
);
    import rrqs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [TIME_W-1:0] clock_reg, clock_next;
    logic [LEN_W-1:0]  quantum_reg;
    logic              m_valid_reg;
    result_t           result_reg;

    logic    accept;
    logic    is_dispatch;
    logic    q_empty;
    logic    q_full;
    logic    do_push_new;
    logic    do_pop;
    logic    do_requeue;
    logic    wr_en;
    entry_t  wr_data;
    entry_t  new_entry;
    entry_t  head_entry;
    entry_t  requeue_entry;
    result_t calc_res;
    logic    calc_done;

    assign s_ready     = !m_valid_reg || m_ready;
    assign accept      = s_valid && s_ready;
    assign is_dispatch = (s_req_type == REQ_DISPATCH);
    assign q_empty     = (occ_reg == '0);
    assign q_full      = (occ_reg == FULL_CNT);

    rrqs_slice_calc u_calc (
        .is_dispatch   (is_dispatch),
        .q_empty       (q_empty),
        .q_full        (q_full),
        .head          (head_entry),
        .clock_cur     (clock_reg),
        .quantum       (quantum_reg),
        .res           (calc_res),
        .task_done     (calc_done),
        .requeue_entry (requeue_entry)
    );

    always_comb begin
        new_entry.id        = s_task_id;
        new_entry.remaining = s_burst_length;
        new_entry.arrival   = clock_reg;
        new_entry.last_enq  = clock_reg;
        new_entry.wait_sum  = '0;

        do_push_new = accept && !is_dispatch && !q_full;
        do_pop      = accept && is_dispatch && !q_empty;
        do_requeue  = do_pop && !calc_done;
        wr_en       = do_push_new || do_requeue;
        wr_data     = do_push_new ? new_entry : requeue_entry;

        head_next = head_reg;
        if (do_pop) begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + PTR_W'(1);
        end
        tail_next = tail_reg;
        if (wr_en) begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + PTR_W'(1);
        end

        // A requeued task leaves and re-enters, so only new tasks and finished
        // tasks change the count.
        occ_next = occ_reg;
        if (do_push_new) begin
            occ_next = occ_reg + CNT_W'(1);
        end else if (do_pop && calc_done) begin
            occ_next = occ_reg - CNT_W'(1);
        end

        clock_next = accept ? calc_res.clock_now : clock_reg;
    end

    // The read address is the head after this cycle, so the head entry is
    // ready in the register when the next request arrives.
    rrqs_entry_ram #(
        .DEPTH (QUEUE_DEPTH),
        .PTR_W (PTR_W)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_addr (head_next),
        .rd_data (head_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            clock_reg   <= '0;
            quantum_reg <= LEN_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            clock_reg <= clock_next;
            if (cfg_wr_en) begin
                quantum_reg <= cfg_wr_data;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= calc_res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = result_reg.status;
    assign m_served_id      = result_reg.served_id;
    assign m_slice_start    = result_reg.slice_start;
    assign m_slice_length   = result_reg.slice_length;
    assign m_wait_this_turn = result_reg.wait_this_turn;
    assign m_time_left      = result_reg.time_left;
    assign m_task_done      = result_reg.task_done;
    assign m_turnaround     = result_reg.turnaround;
    assign m_total_wait     = result_reg.total_wait;
    assign m_clock_now      = result_reg.clock_now;

    `RRQS_ASSERT_NOW(a_occ_bound, aclk, aresetn, 1'b1, occ_reg <= FULL_CNT,
        "occupancy exceeds queue depth")
    `RRQS_ASSERT_NOW(a_ptr_meet, aclk, aresetn, q_empty || q_full, head_reg == tail_reg,
        "head and tail differ on an empty or full ring")
    `RRQS_ASSERT_NEXT(a_clock_step, aclk, aresetn, do_pop,
        clock_reg == m_slice_start + TIME_W'(m_slice_length),
        "clock did not advance by the reported slice")
    `RRQS_ASSERT_NEXT(a_err_hold, aclk, aresetn, accept && !do_push_new && !do_pop,
        occ_reg == $past(occ_reg) && head_reg == $past(head_reg),
        "rejected request changed the ring")
    `RRQS_ASSERT_NEXT(a_full_status, aclk, aresetn, accept && !is_dispatch && q_full,
        m_status == STATUS_FULL && m_valid,
        "add on a full ring not reported as full")

endmodule

`default_nettype wire

FILE: sv/rrqs_entry_ram.sv
// Task ring memory: one write port, one registered read port with write forwarding.
// Depends on rrqs_pkg for entry_t.
`default_nettype none

module rrqs_entry_ram #(
    parameter int DEPTH = 16,
    parameter int PTR_W = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire logic [PTR_W-1:0] wr_addr,
    input  wire rrqs_pkg::entry_t wr_data,
    input  wire logic [PTR_W-1:0] rd_addr,
    output rrqs_pkg::entry_t      rd_data
);
    import rrqs_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;
    entry_t fwd_data_reg;
    logic   fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    // A write to the address being read in the same cycle is not yet in the
    // array, so the written word is handed straight to the read side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/rrqs_slice_calc.sv
// Slice arithmetic and result formation for one request.
// Depends on rrqs_pkg for entry_t, result_t and the status codes.
`default_nettype none

module rrqs_slice_calc (
    input  wire logic                        is_dispatch,
    input  wire logic                        q_empty,
    input  wire logic                        q_full,
    input  wire rrqs_pkg::entry_t            head,
    input  wire logic [rrqs_pkg::TIME_W-1:0] clock_cur,
    input  wire logic [rrqs_pkg::LEN_W-1:0]  quantum,
    output rrqs_pkg::result_t                res,
    output logic                             task_done,
    output rrqs_pkg::entry_t                 requeue_entry
);
    import rrqs_pkg::*;

    logic [LEN_W-1:0]  q_eff;
    logic [LEN_W-1:0]  slice;
    logic [LEN_W-1:0]  rem_after;
    logic [TIME_W-1:0] clock_after;
    logic [TIME_W-1:0] wait_now;
    logic [TIME_W-1:0] wait_total;

    always_comb begin
        // A quantum of zero grants one unit.
        q_eff       = (quantum == '0) ? LEN_W'(1) : quantum;
        slice       = (head.remaining > q_eff) ? q_eff : head.remaining;
        rem_after   = head.remaining - slice;
        clock_after = clock_cur + TIME_W'(slice);
        wait_now    = clock_cur - head.last_enq;
        wait_total  = head.wait_sum + wait_now;
        task_done   = (rem_after == '0);

        requeue_entry.id        = head.id;
        requeue_entry.remaining = rem_after;
        requeue_entry.arrival   = head.arrival;
        requeue_entry.last_enq  = clock_after;
        requeue_entry.wait_sum  = wait_total;

        res           = '0;
        res.clock_now = clock_cur;
        if (!is_dispatch) begin
            res.status = q_full ? STATUS_FULL : STATUS_ADDED;
        end else if (q_empty) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.status         = STATUS_DISPATCHED;
            res.served_id      = head.id;
            res.slice_start    = clock_cur;
            res.slice_length   = slice;
            res.wait_this_turn = wait_now;
            res.time_left      = rem_after;
            res.task_done      = task_done;
            res.turnaround     = task_done ? (clock_after - head.arrival) : '0;
            res.total_wait     = wait_total;
            res.clock_now      = clock_after;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_round_robin_quantum_scheduler_unit.sv
// Testbench for round_robin_quantum_scheduler_unit: a directed run, then random
// add/dispatch traffic checked beat by beat against a scheduler model in the bench.
// Depends on rrqs_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_round_robin_quantum_scheduler_unit;
    import rrqs_pkg::*;

    localparam int QUEUE_DEPTH = 16;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  burst;
    } request_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]    cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_req_type = REQ_ADD;
    logic [ID_W-1:0]     s_task_id = '0;
    logic [LEN_W-1:0]    s_burst_length = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [1:0]          m_status;
    logic [ID_W-1:0]     m_served_id;
    logic [TIME_W-1:0]   m_slice_start;
    logic [LEN_W-1:0]    m_slice_length;
    logic [TIME_W-1:0]   m_wait_this_turn;
    logic [LEN_W-1:0]    m_time_left;
    logic                m_task_done;
    logic [TIME_W-1:0]   m_turnaround;
    logic [TIME_W-1:0]   m_total_wait;
    logic [TIME_W-1:0]   m_clock_now;

    request_t            request_backlog[$];
    result_t             predicted_replies[$];
    int                  beats_offered = 0;
    int                  beats_accepted = 0;
    int                  mismatch_count = 0;
    int                  send_gap = 0;
    int                  ready_gap = 0;
    logic                steady_flow = 1'b0;
    logic                sink_hold = 1'b0;

    // Scheduler state as the bench expects it.
    logic [ID_W-1:0]     slot_id [QUEUE_DEPTH];
    logic [LEN_W-1:0]    slot_left [QUEUE_DEPTH];
    logic [TIME_W-1:0]   slot_arrival [QUEUE_DEPTH];
    logic [TIME_W-1:0]   slot_requeued [QUEUE_DEPTH];
    logic [TIME_W-1:0]   slot_waited [QUEUE_DEPTH];
    int                  ring_head = 0;
    int                  ring_tail = 0;
    int                  ring_count = 0;
    logic [TIME_W-1:0]   sched_time = '0;
    logic [LEN_W-1:0]    quantum_setting = LEN_W'(1);

    round_robin_quantum_scheduler_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_task_id(s_task_id),
        .s_burst_length(s_burst_length),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_served_id(m_served_id),
        .m_slice_start(m_slice_start),
        .m_slice_length(m_slice_length),
        .m_wait_this_turn(m_wait_this_turn),
        .m_time_left(m_time_left),
        .m_task_done(m_task_done),
        .m_turnaround(m_turnaround),
        .m_total_wait(m_total_wait),
        .m_clock_now(m_clock_now)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        else if (roll < 90) return $urandom_range(3, 1);
        else return $urandom_range(20, 6);
    endfunction

    function automatic logic [LEN_W-1:0] random_burst();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 4) return '0;
        else if (roll < 8) return '1;
        else if (roll < 70) return LEN_W'($urandom_range(16, 1));
        else if (roll < 90) return LEN_W'($urandom_range(200, 17));
        else return LEN_W'($urandom_range(1022, 201));
    endfunction

    task automatic push_request(input logic kind, input logic [ID_W-1:0] id,
                                input logic [LEN_W-1:0] burst);
        request_t r;
        r.kind = kind;
        r.id = id;
        r.burst = burst;
        request_backlog.push_back(r);
    endtask

    task automatic queue_random(input int count, input int add_pct);
        for (int n = 0; n < count; n++) begin
            push_request(($urandom_range(99) < add_pct) ? REQ_ADD : REQ_DISPATCH,
                         ID_W'($urandom), random_burst());
        end
    endtask

    task automatic wait_until_drained();
        while (request_backlog.size() != 0 || beats_offered != beats_accepted ||
               predicted_replies.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_quantum(input logic [LEN_W-1:0] value);
        wait_until_drained();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_data = value;
        cfg_wr_en = 1'b1;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Works out the reply to one accepted request and advances the expected state.
    task automatic schedule_request(input logic kind, input logic [ID_W-1:0] id,
                                    input logic [LEN_W-1:0] burst);
        result_t           r;
        int                h;
        logic [LEN_W-1:0]  grant;
        logic [LEN_W-1:0]  slice;
        logic [LEN_W-1:0]  left;
        logic [ID_W-1:0]   tid;
        logic [TIME_W-1:0] arrived;
        r = '0;
        if (kind == REQ_ADD) begin
            if (ring_count >= QUEUE_DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                slot_id[ring_tail] = id;
                slot_left[ring_tail] = burst;
                slot_arrival[ring_tail] = sched_time;
                slot_requeued[ring_tail] = sched_time;
                slot_waited[ring_tail] = '0;
                ring_tail = (ring_tail + 1) % QUEUE_DEPTH;
                ring_count++;
                r.status = STATUS_ADDED;
            end
        end else if (ring_count == 0) begin
            r.status = STATUS_EMPTY;
        end else begin
            h = ring_head;
            tid = slot_id[h];
            arrived = slot_arrival[h];
            left = slot_left[h];
            grant = (quantum_setting == '0) ? LEN_W'(1) : quantum_setting;
            slice = (left > grant) ? grant : left;
            r.status = STATUS_DISPATCHED;
            r.served_id = tid;
            r.slice_start = sched_time;
            r.slice_length = slice;
            r.wait_this_turn = sched_time - slot_requeued[h];
            r.total_wait = slot_waited[h] + r.wait_this_turn;
            ring_head = (h + 1) % QUEUE_DEPTH;
            ring_count--;
            sched_time = sched_time + TIME_W'(slice);
            left = left - slice;
            r.time_left = left;
            r.task_done = (left == '0);
            if (left == '0) begin
                r.turnaround = sched_time - arrived;
            end else begin
                // The head has already left, so putting it back cannot overflow.
                slot_id[ring_tail] = tid;
                slot_left[ring_tail] = left;
                slot_arrival[ring_tail] = arrived;
                slot_requeued[ring_tail] = sched_time;
                slot_waited[ring_tail] = r.total_wait;
                ring_tail = (ring_tail + 1) % QUEUE_DEPTH;
                ring_count++;
            end
        end
        r.clock_now = sched_time;
        predicted_replies.push_back(r);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            if (mismatch_count < 40)
                $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_reply();
        result_t want;
        if (predicted_replies.size() == 0) begin
            if (mismatch_count < 40)
                $display("%0t: result beat with nothing expected, status %0h",
                         $time, m_status);
            mismatch_count++;
        end else begin
            want = predicted_replies.pop_front();
            compare_field("status", 32'(want.status), 32'(m_status));
            compare_field("served_id", 32'(want.served_id), 32'(m_served_id));
            compare_field("slice_start", want.slice_start, m_slice_start);
            compare_field("slice_length", 32'(want.slice_length), 32'(m_slice_length));
            compare_field("wait_this_turn", want.wait_this_turn, m_wait_this_turn);
            compare_field("time_left", 32'(want.time_left), 32'(m_time_left));
            compare_field("task_done", 32'(want.task_done), 32'(m_task_done));
            compare_field("turnaround", want.turnaround, m_turnaround);
            compare_field("total_wait", want.total_wait, m_total_wait);
            compare_field("clock_now", want.clock_now, m_clock_now);
        end
    endtask

    // Monitor and predictor: outputs are sampled at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                quantum_setting = cfg_wr_data;
            if (m_valid && m_ready)
                check_reply();
            if (s_valid && s_ready) begin
                schedule_request(s_req_type, s_task_id, s_burst_length);
                beats_accepted++;
            end
        end
    end

    // Request driver: a beat stays on the port until it is taken.
    always @(negedge aclk) begin : request_driver
        request_t next_req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && beats_offered != beats_accepted) begin
        end else if (send_gap > 0) begin
            s_valid <= 1'b0;
            send_gap--;
        end else if (request_backlog.size() != 0) begin
            next_req = request_backlog.pop_front();
            s_valid <= 1'b1;
            s_req_type <= next_req.kind;
            s_task_id <= next_req.id;
            s_burst_length <= next_req.burst;
            beats_offered++;
            send_gap = steady_flow ? 0 : pick_gap();
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (sink_hold) begin
            m_ready <= 1'b0;
        end else if (steady_flow) begin
            m_ready <= 1'b1;
        end else if (ready_gap > 0) begin
            m_ready <= 1'b0;
            ready_gap--;
        end else begin
            m_ready <= 1'b1;
            ready_gap = pick_gap();
        end
    end

    // Long back-pressure in the middle of a phase, so the block fills up.
    initial begin
        while (beats_accepted < 270)
            @(posedge aclk);
        sink_hold = 1'b1;
        repeat (80) @(posedge aclk);
        sink_hold = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset quantum: empty dispatch, zero and maximum bursts, short tasks.
        push_request(REQ_DISPATCH, '1, '1);
        push_request(REQ_ADD, '0, '0);
        push_request(REQ_ADD, '1, '1);
        push_request(REQ_ADD, 16'h5A5A, LEN_W'(1));
        repeat (4) push_request(REQ_DISPATCH, '0, '0);

        // A zero quantum behaves as one; fill the ring, overflow it, then
        // dispatch from the full ring so the head is requeued.
        write_quantum('0);
        for (int k = 0; k < QUEUE_DEPTH - 1; k++)
            push_request(REQ_ADD, ID_W'(16'h1000 + k), LEN_W'(k + 2));
        push_request(REQ_ADD, 16'hBEEF, LEN_W'(5));
        push_request(REQ_DISPATCH, '0, '0);

        write_quantum('1);
        queue_random(100, 50);
        write_quantum(LEN_W'(1));
        queue_random(100, 75);
        write_quantum(LEN_W'(7));
        queue_random(100, 40);
        write_quantum(LEN_W'($urandom_range(1022, 2)));
        steady_flow = 1'b1;
        queue_random(100, 55);
        write_quantum(LEN_W'(512));
        steady_flow = 1'b0;
        queue_random(60, 30);
        write_quantum(LEN_W'(3));
        queue_random(70, 50);

        wait_until_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && predicted_replies.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
